// ----- rtl/bis_pkg.sv -----
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, constants and the lane blend for the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int LANE_BITS  = 8;
    localparam int LANES      = 4;
    localparam int PIX_W      = LANE_BITS * LANES;
    localparam int IDX_W      = 12;
    localparam int STEP_W     = 24;
    localparam int SIZE_W     = 9;
    localparam int POS_W      = IDX_W + STEP_W;
    localparam int LIM_W      = 13;
    localparam int CFG_IDX_W  = 2;

    typedef logic [FRAC_BITS:0] frac_t;

    localparam frac_t ONE_FIXED = frac_t'(1) << FRAC_BITS;

    typedef enum logic
    {
        FUNC_LOAD   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_X_STEP     = 2'd2,
        REG_Y_STEP     = 2'd3
    } cfg_reg_t;

    typedef struct packed
    {
        func_t             func;
        logic              in_range;
        logic [IDX_W-1:0]  ix;
        logic [IDX_W-1:0]  iy;
        frac_t             fx;
        frac_t             fy;
    } pos_t;

    function automatic logic [LANE_BITS-1:0] blend_lane
    (
        input logic [LANE_BITS-1:0] a,
        input logic [LANE_BITS-1:0] b,
        input frac_t                f
    );
        logic [FRAC_BITS+LANE_BITS:0] s;
        s = (FRAC_BITS+LANE_BITS+1)'(a) * (FRAC_BITS+LANE_BITS+1)'(ONE_FIXED - f)
          + (FRAC_BITS+LANE_BITS+1)'(b) * (FRAC_BITS+LANE_BITS+1)'(f);
        return s[FRAC_BITS+LANE_BITS-1:FRAC_BITS];
    endfunction

endpackage

// ----- rtl/bis_ram.sv -----
// ----------------------------------------------------------------------------
// bis_ram
// Single-port synchronous RAM, one write and one read per cycle on one address, registered read.
// ----------------------------------------------------------------------------
module bis_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bis_map.sv -----
// ----------------------------------------------------------------------------
// bis_map
// Position mapping: a sample's destination coordinate is scaled by the step, then split
// into a clamped source index and a saturated 16-bit fraction; a load's coordinate is the index.
// ----------------------------------------------------------------------------
module bis_map
    import bis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  func_t             func,
    input  logic [IDX_W-1:0]  col,
    input  logic [IDX_W-1:0]  row,
    input  logic [PIX_W-1:0]  load_pixel,
    input  logic [STEP_W-1:0] x_step,
    input  logic [STEP_W-1:0] y_step,
    input  logic [LIM_W-1:0]  lim_x,
    input  logic [LIM_W-1:0]  lim_y,
    output logic              s1_valid,
    output pos_t              s1_pos,
    output logic [PIX_W-1:0]  s1_pixel
);

    localparam int IP_W = POS_W - FRAC_BITS;

    logic              v0_reg;
    func_t             func0_reg;
    logic [IDX_W-1:0]  col0_reg;
    logic [IDX_W-1:0]  row0_reg;
    logic [POS_W-1:0]  xt0_reg;
    logic [POS_W-1:0]  yt0_reg;
    logic [PIX_W-1:0]  pix0_reg;

    logic              v1_reg;
    pos_t              pos1_reg;
    pos_t              pos1_next;
    logic [PIX_W-1:0]  pix1_reg;

    logic [IP_W-1:0]   ipx;
    logic [IP_W-1:0]   ipy;
    logic              clamp_x;
    logic              clamp_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func0_reg <= func;
            col0_reg  <= col;
            row0_reg  <= row;
            xt0_reg   <= POS_W'(col) * POS_W'(x_step);
            yt0_reg   <= POS_W'(row) * POS_W'(y_step);
            pix0_reg  <= load_pixel;
            pos1_reg  <= pos1_next;
            pix1_reg  <= pix0_reg;
        end
    end

    always_comb
    begin
        ipx     = xt0_reg[POS_W-1:FRAC_BITS];
        ipy     = yt0_reg[POS_W-1:FRAC_BITS];
        clamp_x = ipx > IP_W'(lim_x);
        clamp_y = ipy > IP_W'(lim_y);

        pos1_next.func     = func0_reg;
        pos1_next.in_range = (LIM_W'(col0_reg) < LIM_W'(MAX_SRC_WIDTH))
                          && (LIM_W'(row0_reg) < LIM_W'(MAX_SRC_HEIGHT));
        if (func0_reg == FUNC_LOAD)
        begin
            pos1_next.ix = col0_reg;
            pos1_next.iy = row0_reg;
        end
        else
        begin
            pos1_next.ix = clamp_x ? lim_x[IDX_W-1:0] : ipx[IDX_W-1:0];
            pos1_next.iy = clamp_y ? lim_y[IDX_W-1:0] : ipy[IDX_W-1:0];
        end
        pos1_next.fx = clamp_x ? ONE_FIXED : {1'b0, xt0_reg[FRAC_BITS-1:0]};
        pos1_next.fy = clamp_y ? ONE_FIXED : {1'b0, yt0_reg[FRAC_BITS-1:0]};
    end

    assign s1_valid = v1_reg;
    assign s1_pos   = pos1_reg;
    assign s1_pixel = pix1_reg;

endmodule

// ----- rtl/bis_blend.sv -----
// ----------------------------------------------------------------------------
// bis_blend
// Lane blend: horizontal pass into a register, vertical pass after it.
// ----------------------------------------------------------------------------
module bis_blend
    import bis_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [PIX_W-1:0] tl,
    input  logic [PIX_W-1:0] tr,
    input  logic [PIX_W-1:0] bl,
    input  logic [PIX_W-1:0] br,
    input  frac_t            fx,
    input  frac_t            fy,
    output logic             out_valid,
    output logic [PIX_W-1:0] pixel
);

    logic             v_reg;
    logic [PIX_W-1:0] top_reg;
    logic [PIX_W-1:0] top_next;
    logic [PIX_W-1:0] bot_reg;
    logic [PIX_W-1:0] bot_next;
    frac_t            fy_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            top_next[l*LANE_BITS +: LANE_BITS] = blend_lane(tl[l*LANE_BITS +: LANE_BITS],
                                                            tr[l*LANE_BITS +: LANE_BITS], fx);
            bot_next[l*LANE_BITS +: LANE_BITS] = blend_lane(bl[l*LANE_BITS +: LANE_BITS],
                                                            br[l*LANE_BITS +: LANE_BITS], fx);
            pixel[l*LANE_BITS +: LANE_BITS]    = blend_lane(top_reg[l*LANE_BITS +: LANE_BITS],
                                                            bot_reg[l*LANE_BITS +: LANE_BITS],
                                                            fy_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            fy_reg  <= fy;
        end
    end

    assign out_valid = v_reg;

endmodule

// ----- rtl/bilinear_image_scaler.sv -----
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Bilinear scaler over a four-bank source frame store.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): func selects a load beat, which writes
// load_pixel at source (col, row), or a sample beat, which maps (col, row)
// through x_step/y_step and returns one blended pixel on the output channel
// (out_valid/out_ready). Loads outside the store are dropped and give no beat.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; write it only while no sample is in flight.
// The store is split into four banks by row and column parity, so all four
// neighbors are read in the same cycle: one beat enters per clock, and a
// sample's result passes through map, split, bank read, horizontal blend
// and vertical blend into the output register.
// When the output register holds a beat that is not taken, the whole
// pipeline freezes and in_ready drops until out_ready returns.
// Reset clears the pipeline and restores the register defaults; the frame
// store is not cleared and must be loaded before it is sampled.
// ----------------------------------------------------------------------------
module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [IDX_W-1:0]     col,
    input  logic [IDX_W-1:0]     row,
    input  logic [PIX_W-1:0]     load_pixel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     out_pixel,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_data
);

    localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int ADDR_W     = 24;

    logic [SIZE_W-1:0]  src_width_reg;
    logic [SIZE_W-1:0]  src_height_reg;
    logic [STEP_W-1:0]  x_step_reg;
    logic [STEP_W-1:0]  y_step_reg;
    logic [LIM_W-1:0]   lim_x;
    logic [LIM_W-1:0]   lim_y;
    logic [LIM_W-1:0]   w_clamped;
    logic [LIM_W-1:0]   h_clamped;

    logic               en;
    logic               s1_valid;
    pos_t               s1_pos;
    logic [PIX_W-1:0]   s1_pixel;

    logic [IDX_W-1:0]   col_sel [2];
    logic [IDX_W-1:0]   row_sel [2];
    logic [BANK_AW-1:0] bank_addr [4];
    logic               bank_we [4];
    logic [PIX_W-1:0]   bank_rdata [4];

    logic               s2_valid_reg;
    logic               s2_ix0_reg;
    logic               s2_iy0_reg;
    frac_t              s2_fx_reg;
    frac_t              s2_fy_reg;

    logic [PIX_W-1:0]   tl;
    logic [PIX_W-1:0]   tr;
    logic [PIX_W-1:0]   bl;
    logic [PIX_W-1:0]   br;
    logic               s3_valid;
    logic [PIX_W-1:0]   s3_pixel;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_pixel_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SIZE_W'(256);
            src_height_reg <= SIZE_W'(256);
            x_step_reg     <= STEP_W'(65536);
            y_step_reg     <= STEP_W'(65536);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SIZE_W-1:0];
                REG_X_STEP:     x_step_reg     <= cfg_data;
                REG_Y_STEP:     y_step_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (src_width_reg < SIZE_W'(2))
        begin
            w_clamped = LIM_W'(2);
        end
        else if (LIM_W'(src_width_reg) > LIM_W'(MAX_SRC_WIDTH))
        begin
            w_clamped = LIM_W'(MAX_SRC_WIDTH);
        end
        else
        begin
            w_clamped = LIM_W'(src_width_reg);
        end

        if (src_height_reg < SIZE_W'(2))
        begin
            h_clamped = LIM_W'(2);
        end
        else if (LIM_W'(src_height_reg) > LIM_W'(MAX_SRC_HEIGHT))
        begin
            h_clamped = LIM_W'(MAX_SRC_HEIGHT);
        end
        else
        begin
            h_clamped = LIM_W'(src_height_reg);
        end

        lim_x = w_clamped - LIM_W'(2);
        lim_y = h_clamped - LIM_W'(2);
    end

    // advance unless the output register holds a beat that is not taken
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    bis_map
    #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    )
    u_map
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .func       (func_t'(func)),
        .col        (col),
        .row        (row),
        .load_pixel (load_pixel),
        .x_step     (x_step_reg),
        .y_step     (y_step_reg),
        .lim_x      (lim_x),
        .lim_y      (lim_y),
        .s1_valid   (s1_valid),
        .s1_pos     (s1_pos),
        .s1_pixel   (s1_pixel)
    );

    // bank 0 of each axis holds even indexes, bank 1 odd ones
    always_comb
    begin
        col_sel[0] = IDX_W'((LIM_W'(s1_pos.ix) + LIM_W'(1)) >> 1);
        col_sel[1] = s1_pos.ix >> 1;
        row_sel[0] = IDX_W'((LIM_W'(s1_pos.iy) + LIM_W'(1)) >> 1);
        row_sel[1] = s1_pos.iy >> 1;
        for (int b = 0; b < 4; b++)
        begin
            bank_addr[b] = BANK_AW'(ADDR_W'(row_sel[b / 2]) * ADDR_W'(HALF_W)
                                  + ADDR_W'(col_sel[b % 2]));
            bank_we[b]   = en && s1_valid && (s1_pos.func == FUNC_LOAD)
                        && s1_pos.in_range
                        && ({s1_pos.iy[0], s1_pos.ix[0]} == 2'(b));
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        bis_ram
        #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        )
        u_bank
        (
            .clk   (clk),
            .we    (bank_we[g]),
            .re    (en),
            .addr  (bank_addr[g]),
            .wdata (s1_pixel),
            .rdata (bank_rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid && (s1_pos.func == FUNC_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ix0_reg <= s1_pos.ix[0];
            s2_iy0_reg <= s1_pos.iy[0];
            s2_fx_reg  <= s1_pos.fx;
            s2_fy_reg  <= s1_pos.fy;
        end
    end

    always_comb
    begin
        tl = bank_rdata[{s2_iy0_reg, s2_ix0_reg}];
        tr = bank_rdata[{s2_iy0_reg, ~s2_ix0_reg}];
        bl = bank_rdata[{~s2_iy0_reg, s2_ix0_reg}];
        br = bank_rdata[{~s2_iy0_reg, ~s2_ix0_reg}];
    end

    bis_blend u_blend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .tl        (tl),
        .tr        (tr),
        .bl        (bl),
        .br        (br),
        .fx        (s2_fx_reg),
        .fy        (s2_fy_reg),
        .out_valid (s3_valid),
        .pixel     (s3_pixel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pixel_reg <= s3_pixel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

endmodule

// ----- tb/bilinear_image_scaler_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler_test
// Self-checking bench for the bilinear image scaler. A queue-fed driver
// pushes load and sample beats and a clocked monitor predicts every sampled
// pixel from its own copy of the frame store and the register settings,
// then compares it with each output beat in order. Phases change the
// source size and steps and vary idling on both channels, and one phase
// holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_test;
    import bis_pkg::*;

    localparam int SRC_MAX         = 256;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int PRESSURE_PHASE  = 4;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed
    {
        func_t             kind;
        logic [IDX_W-1:0]  x;
        logic [IDX_W-1:0]  y;
        logic [PIX_W-1:0]  pixel;
    } scaler_beat_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic                 func       = 1'b0;
    logic [IDX_W-1:0]     col        = '0;
    logic [IDX_W-1:0]     row        = '0;
    logic [PIX_W-1:0]     load_pixel = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [PIX_W-1:0]     out_pixel;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [STEP_W-1:0]    cfg_data   = '0;

    logic [SIZE_W-1:0]    width_cfg  = 9'd256;
    logic [SIZE_W-1:0]    height_cfg = 9'd256;
    logic [STEP_W-1:0]    xstep_cfg  = 24'h010000;
    logic [STEP_W-1:0]    ystep_cfg  = 24'h010000;

    logic [PIX_W-1:0]     frame_copy [0:SRC_MAX*SRC_MAX-1];
    bit                   loaded     [0:SRC_MAX*SRC_MAX-1];

    scaler_beat_t         feed_q[$];
    logic [PIX_W-1:0]     pending_pixels[$];

    int                   send_idle_pct  = 0;
    int                   stall_pct      = 0;
    int                   hold_requests  = 0;
    int                   holds_served   = 0;
    int                   hold_left      = 0;
    int                   phase_items    = 0;
    int                   cfg_writes     = 0;
    int                   errors         = 0;
    int                   cycles         = 0;
    int                   loads_in       = 0;
    int                   samples_in     = 0;
    int                   pixels_checked = 0;
    bit                   in_beat        = 1'b0;

    bilinear_image_scaler
    #(
        .MAX_SRC_WIDTH  (SRC_MAX),
        .MAX_SRC_HEIGHT (SRC_MAX)
    )
    dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .col        (col),
        .row        (row),
        .load_pixel (load_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_pixel  (out_pixel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v);
        if (v < 2)
        begin
            return 9'd2;
        end
        if (v > SRC_MAX)
        begin
            return 9'(SRC_MAX);
        end
        return v;
    endfunction

    function automatic logic [15:0] frame_addr(input logic [IDX_W-1:0] x,
                                               input logic [IDX_W-1:0] y);
        return 16'(y * SRC_MAX + x);
    endfunction

    // integer part clamped to size - 2, fraction saturated at 1.0
    function automatic void split_axis(input  logic [IDX_W-1:0]  idx,
                                       input  logic [STEP_W-1:0] step,
                                       input  logic [SIZE_W-1:0] size,
                                       output logic [IDX_W-1:0]  ipart,
                                       output frac_t             fpart);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] whole;
        logic [POS_W-1:0] rem;
        pos   = POS_W'(idx) * POS_W'(step);
        whole = pos >> FRAC_BITS;
        if (whole > POS_W'(size - 9'd2))
        begin
            whole = POS_W'(size - 9'd2);
        end
        rem = pos - (whole << FRAC_BITS);
        if (rem > POS_W'(ONE_FIXED))
        begin
            rem = POS_W'(ONE_FIXED);
        end
        ipart = whole[IDX_W-1:0];
        fpart = rem[FRAC_BITS:0];
    endfunction

    function automatic logic [LANE_BITS-1:0] mix8(input logic [LANE_BITS-1:0] a,
                                                  input logic [LANE_BITS-1:0] b,
                                                  input frac_t                f);
        logic [31:0] acc;
        acc = 32'(a) * 32'(ONE_FIXED - f) + 32'(b) * 32'(f);
        return acc[FRAC_BITS +: LANE_BITS];
    endfunction

    function automatic logic [PIX_W-1:0] interpolate_pixel(input logic [IDX_W-1:0] c,
                                                           input logic [IDX_W-1:0] r);
        logic [IDX_W-1:0]     ix;
        logic [IDX_W-1:0]     iy;
        frac_t                fx;
        frac_t                fy;
        logic [PIX_W-1:0]     tl;
        logic [PIX_W-1:0]     tr;
        logic [PIX_W-1:0]     bl;
        logic [PIX_W-1:0]     br;
        logic [PIX_W-1:0]     res;
        logic [LANE_BITS-1:0] top;
        logic [LANE_BITS-1:0] bot;
        split_axis(c, xstep_cfg, sat_size(width_cfg), ix, fx);
        split_axis(r, ystep_cfg, sat_size(height_cfg), iy, fy);
        tl = frame_copy[frame_addr(ix, iy)];
        tr = frame_copy[frame_addr(ix + 12'd1, iy)];
        bl = frame_copy[frame_addr(ix, iy + 12'd1)];
        br = frame_copy[frame_addr(ix + 12'd1, iy + 12'd1)];
        res = '0;
        for (int l = 0; l < LANES; l++)
        begin
            top = mix8(tl[l*LANE_BITS +: LANE_BITS], tr[l*LANE_BITS +: LANE_BITS], fx);
            bot = mix8(bl[l*LANE_BITS +: LANE_BITS], br[l*LANE_BITS +: LANE_BITS], fx);
            res[l*LANE_BITS +: LANE_BITS] = mix8(top, bot, fy);
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // mostly coordinates that land inside the source image
    function automatic logic [IDX_W-1:0] pick_coord(input logic [SIZE_W-1:0] size,
                                                    input logic [STEP_W-1:0] step,
                                                    input bit                wide);
        int unsigned span;
        if (wide || step == 0)
        begin
            return IDX_W'($urandom_range(4095));
        end
        span = ((32'(sat_size(size)) - 1) * 32'h10000) / 32'(step);
        if (span > 4095)
        begin
            span = 4095;
        end
        return IDX_W'($urandom_range(span));
    endfunction

    task automatic push_beat(input func_t            kind,
                             input logic [IDX_W-1:0] x,
                             input logic [IDX_W-1:0] y,
                             input logic [PIX_W-1:0] pixel);
        scaler_beat_t b;
        b.kind  = kind;
        b.x     = x;
        b.y     = y;
        b.pixel = pixel;
        feed_q.push_back(b);
    endtask

    task automatic queue_load(input logic [IDX_W-1:0] x,
                              input logic [IDX_W-1:0] y,
                              input logic [PIX_W-1:0] pixel);
        push_beat(FUNC_LOAD, x, y, pixel);
        if (x < SRC_MAX && y < SRC_MAX)
        begin
            loaded[frame_addr(x, y)] = 1'b1;
            phase_items++;
        end
    endtask

    // load any neighbor not yet written, then sample
    task automatic queue_sample(input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] r);
        logic [IDX_W-1:0] ix;
        logic [IDX_W-1:0] iy;
        logic [IDX_W-1:0] nx;
        logic [IDX_W-1:0] ny;
        frac_t            fx;
        frac_t            fy;
        split_axis(c, xstep_cfg, sat_size(width_cfg), ix, fx);
        split_axis(r, ystep_cfg, sat_size(height_cfg), iy, fy);
        for (int k = 0; k < 4; k++)
        begin
            nx = ix + IDX_W'(k % 2);
            ny = iy + IDX_W'(k / 2);
            if (!loaded[frame_addr(nx, ny)])
            begin
                queue_load(nx, ny, rand_pixel());
            end
        end
        push_beat(FUNC_SAMPLE, c, r, PIX_W'($urandom));
        phase_items++;
    endtask

    task automatic random_item();
        int               pick;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] r;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            c = (pick < 3) ? IDX_W'($urandom_range(4095)) : IDX_W'($urandom_range(SRC_MAX - 1));
            r = (pick >= 3 && pick < 6) ? IDX_W'($urandom_range(4095))
                                        : IDX_W'($urandom_range(SRC_MAX - 1));
            queue_load(c, r, rand_pixel());
        end
        else
        begin
            c = pick_coord(width_cfg, xstep_cfg, pick < 30);
            r = pick_coord(height_cfg, ystep_cfg, pick < 30);
            queue_sample(c, r);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [STEP_W-1:0] value);
        int seen;
        @(negedge clk);
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        while (cfg_writes == seen)
        begin
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (feed_q.size() != 0 || in_valid || pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic report(input string what, input logic [PIX_W-1:0] want,
                          input logic [PIX_W-1:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("%s at cycle %0d: expected %08h, got %08h", what, cycles, want, got);
        end
    endtask

    // sender: hold the beat until taken, otherwise advance or idle
    always @(negedge clk)
    begin
        scaler_beat_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_beat)
        begin
            in_valid <= 1'b1;
        end
        else if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            nxt = feed_q.pop_front();
            in_valid   <= 1'b1;
            func       <= nxt.kind;
            col        <= nxt.x;
            row        <= nxt.y;
            load_pixel <= nxt.pixel;
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold on request
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        logic [PIX_W-1:0] want;
        in_beat = in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                case (cfg_reg_t'(cfg_index))
                    REG_SRC_WIDTH:  width_cfg  = cfg_data[SIZE_W-1:0];
                    REG_SRC_HEIGHT: height_cfg = cfg_data[SIZE_W-1:0];
                    REG_X_STEP:     xstep_cfg  = cfg_data;
                    REG_Y_STEP:     ystep_cfg  = cfg_data;
                    default: ;
                endcase
            end
            if (in_beat)
            begin
                if (func == FUNC_LOAD)
                begin
                    loads_in++;
                    if (col < SRC_MAX && row < SRC_MAX)
                    begin
                        frame_copy[frame_addr(col, row)] = load_pixel;
                    end
                end
                else
                begin
                    samples_in++;
                    pending_pixels.push_back(interpolate_pixel(col, row));
                end
            end
            if (out_valid && out_ready)
            begin
                pixels_checked++;
                if (pending_pixels.size() == 0)
                begin
                    report("Unexpected output beat", '0, out_pixel);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (out_pixel !== want)
                    begin
                        report("Pixel mismatch", want, out_pixel);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [SIZE_W-1:0] w_raw;
        logic [SIZE_W-1:0] h_raw;
        logic [STEP_W-1:0] xs;
        logic [STEP_W-1:0] ys;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase

            if (ph != 0)
            begin
                case (ph)
                    1:
                    begin
                        w_raw = 9'd2; h_raw = 9'd2; xs = 24'h008000; ys = 24'h004000;
                    end
                    2:
                    begin
                        w_raw = 9'd256; h_raw = 9'd256;
                        xs = STEP_W'($urandom_range(24'h004000, 24'h040000)); ys = '0;
                    end
                    3:
                    begin
                        w_raw = 9'd0; h_raw = 9'd511; xs = 24'hFFFFFF; ys = 24'h000001;
                    end
                    4:
                    begin
                        w_raw = SIZE_W'($urandom_range(2, 16));
                        h_raw = SIZE_W'($urandom_range(2, 16));
                        xs = STEP_W'($urandom_range(24'h001000, 24'h030000));
                        ys = STEP_W'($urandom_range(24'h001000, 24'h030000));
                    end
                    5:
                    begin
                        w_raw = SIZE_W'($urandom_range(17, 64));
                        h_raw = SIZE_W'($urandom_range(3, 64));
                        xs = '0; ys = 24'hFFFFFF;
                    end
                    6:
                    begin
                        w_raw = 9'd256; h_raw = 9'd256;
                        xs = STEP_W'($urandom_range(24'h002000, 24'h020000));
                        ys = STEP_W'($urandom_range(24'h002000, 24'h020000));
                    end
                    default:
                    begin
                        w_raw = SIZE_W'($urandom_range(511));
                        h_raw = SIZE_W'($urandom_range(511));
                        xs = STEP_W'($urandom);
                        ys = STEP_W'($urandom_range(24'h030000));
                    end
                endcase
                write_reg(REG_SRC_WIDTH,  (STEP_W'($urandom) & 24'hFFFE00) | STEP_W'(w_raw));
                write_reg(REG_SRC_HEIGHT, (STEP_W'($urandom) & 24'hFFFE00) | STEP_W'(h_raw));
                write_reg(REG_X_STEP, xs);
                write_reg(REG_Y_STEP, ys);
            end

            phase_items = 0;
            if (ph == 0)
            begin
                queue_load(12'd0, 12'd0, 32'h00000000);
                queue_load(12'd1, 12'd0, 32'hFFFFFFFF);
                queue_load(12'd0, 12'd1, 32'hA5C30F96);
                queue_load(12'd1, 12'd1, 32'h5A3CF069);
                queue_load(12'd256, 12'd0, 32'hFFFFFFFF);
                queue_load(12'd0, 12'd256, 32'hFFFFFFFF);
                queue_load(12'd4095, 12'd4095, 32'hFFFFFFFF);
                queue_sample(12'd0, 12'd0);
                queue_sample(12'd1, 12'd1);
                queue_load(12'd254, 12'd254, 32'h12345678);
                queue_load(12'd255, 12'd254, 32'hFFFFFFFF);
                queue_load(12'd254, 12'd255, 32'h00000000);
                queue_load(12'd255, 12'd255, 32'h87654321);
                queue_sample(12'd254, 12'd254);
                queue_sample(12'd255, 12'd255);
                queue_sample(12'd4095, 12'd4095);
                queue_sample(12'd4095, 12'd0);
                queue_sample(12'd0, 12'd4095);
                queue_load(12'd0, 12'd0, 32'hFFFFFFFF);
                queue_sample(12'd0, 12'd0);
            end
            while (phase_items < ITEMS_PER_PHASE)
            begin
                random_item();
            end
            if (ph == PRESSURE_PHASE)
            begin
                hold_requests++;
            end
            drain();
        end

        errors += pending_pixels.size();
        $display("Covered %0d load and %0d sample beats, %0d pixels compared, %0d settings",
                 loads_in, samples_in, pixels_checked, PHASES);
        $display("Steps from zero to maximum, edge clamping, size saturation, %0d-cycle hold",
                 LONG_HOLD);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bis_pkg.sv
rtl/bis_ram.sv
rtl/bis_map.sv
rtl/bis_blend.sv
rtl/bilinear_image_scaler.sv
tb/bilinear_image_scaler_test.sv
